FILE: sv/simon_pkg.sv
// ----------------------------------------------------------------------------
// simon_pkg
// shared widths, round count, z2 constant sequence and the stage payload type
// ----------------------------------------------------------------------------
package simon_pkg;

    localparam int WORD_W      = 64;
    localparam int ROUND_COUNT = 68;
    localparam int Z2_LEN      = 62;

    localparam logic [Z2_LEN-1:0] Z2_SEQ = Z2_LEN'(64'h2BDC0D262847E5B3);

    localparam int CFG_INDEX_W = 1;

    localparam logic [CFG_INDEX_W-1:0] REG_KEY_LOW  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_HIGH = 1'd1;

    typedef logic [WORD_W-1:0] word_t;

    // cipher halves and the two most recent round keys
    typedef struct packed {
        word_t x;
        word_t y;
        word_t kprev2;
        word_t kprev1;
    } stage_t;

    function automatic word_t rotl(input word_t v, input logic [5:0] s);
        rotl = (v << s) | (v >> (7'(WORD_W) - {1'b0, s}));
    endfunction

    function automatic word_t rotr(input word_t v, input logic [5:0] s);
        rotr = (v >> s) | (v << (7'(WORD_W) - {1'b0, s}));
    endfunction

endpackage

FILE: sv/simon_round_stage.sv
// ----------------------------------------------------------------------------
// simon_round_stage
// one feistel round plus one key expansion step, registered
// ----------------------------------------------------------------------------
module simon_round_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  simon_pkg::stage_t in_data,
    input  logic              zbit,
    output logic              out_valid,
    output simon_pkg::stage_t out_data
);

    logic              valid_reg;
    simon_pkg::stage_t data_reg;
    simon_pkg::stage_t data_next;
    simon_pkg::word_t  t_rot;
    simon_pkg::word_t  t_mix;

    always_comb
    begin
        data_next.x = in_data.y
                    ^ (simon_pkg::rotl(in_data.x, 6'd1) & simon_pkg::rotl(in_data.x, 6'd8))
                    ^ simon_pkg::rotl(in_data.x, 6'd2)
                    ^ in_data.kprev2;
        data_next.y = in_data.x;

        t_rot = simon_pkg::rotr(in_data.kprev1, 6'd3);
        t_mix = t_rot ^ simon_pkg::rotr(t_rot, 6'd1);
        data_next.kprev2 = in_data.kprev1;
        data_next.kprev1 = ~in_data.kprev2 ^ t_mix
                         ^ {{(simon_pkg::WORD_W-1){1'b0}}, zbit}
                         ^ simon_pkg::WORD_W'(3);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

FILE: sv/simon128_128_block_encrypt_core.sv
// ----------------------------------------------------------------------------
// simon128_128_block_encrypt_core
// simon 128/128 encryption, fully unrolled, one round per pipeline stage
// ----------------------------------------------------------------------------
//  channel   dir  width  contents
//  s_axis    in   128    plaintext beat: plain_right, plain_left
//  m_axis    out  128    ciphertext beat: cipher_right, cipher_left
//  cfg       in   64     key word writes, index 0 = low, 1 = high
//
//  one beat per cycle in and out while the pipe is not held; one round per
//  stage, each stage holding one feistel round and one key expansion step.
//  the last stage is the output register; when it is full and m_axis_tready
//  is low the whole pipe holds and s_axis_tready drops.
//  reset clears all stage valid bits and both key words.
// ----------------------------------------------------------------------------
module simon128_128_block_encrypt_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [2*simon_pkg::WORD_W-1:0]       s_axis_tdata,  // plain_right, plain_left
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [2*simon_pkg::WORD_W-1:0]       m_axis_tdata,  // cipher_right, cipher_left
    input  logic                                 cfg_wen,
    input  logic [simon_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [simon_pkg::WORD_W-1:0]         cfg_wdata
);

    simon_pkg::word_t  key_low_reg;
    simon_pkg::word_t  key_high_reg;
    logic              advance;
    logic              stage_valid [simon_pkg::ROUND_COUNT+1];
    simon_pkg::stage_t stage_data  [simon_pkg::ROUND_COUNT+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg  <= '0;
            key_high_reg <= '0;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_index)
                simon_pkg::REG_KEY_LOW:  key_low_reg  <= cfg_wdata;
                simon_pkg::REG_KEY_HIGH: key_high_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // whole pipe moves unless the output register is full and stalled
    assign advance       = !stage_valid[simon_pkg::ROUND_COUNT] || m_axis_tready;
    assign s_axis_tready = advance;

    assign stage_valid[0]       = s_axis_tvalid;
    assign stage_data[0].y      = s_axis_tdata[simon_pkg::WORD_W-1:0];
    assign stage_data[0].x      = s_axis_tdata[2*simon_pkg::WORD_W-1:simon_pkg::WORD_W];
    assign stage_data[0].kprev2 = key_low_reg;
    assign stage_data[0].kprev1 = key_high_reg;

    for (genvar r = 0; r < simon_pkg::ROUND_COUNT; r++)
    begin : g_round
        simon_round_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (advance),
            .in_valid  (stage_valid[r]),
            .in_data   (stage_data[r]),
            .zbit      (simon_pkg::Z2_SEQ[simon_pkg::Z2_LEN-1 - (r % simon_pkg::Z2_LEN)]),
            .out_valid (stage_valid[r+1]),
            .out_data  (stage_data[r+1])
        );
    end

    assign m_axis_tvalid = stage_valid[simon_pkg::ROUND_COUNT];
    assign m_axis_tdata  = {stage_data[simon_pkg::ROUND_COUNT].x,
                            stage_data[simon_pkg::ROUND_COUNT].y};

endmodule

FILE: tb/sv/simon128_128_block_encrypt_core_tb.sv
// ----------------------------------------------------------------------------
// simon128_128_block_encrypt_core_tb
// self-checking bench: plaintext beats go in on s_axis with random gaps and
// ciphertext beats are taken from m_axis with random back-pressure. each
// accepted beat is enciphered by a local round/key-schedule model, or read from
// the table, and the result queued; every output beat is checked against the
// oldest entry. a short table of directed blocks and keys is followed by random
// phases, each under its own key, written only once the pipe has drained.
// ----------------------------------------------------------------------------
module simon128_128_block_encrypt_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RAND_PHASES  = 13;
    localparam int PHASE_BLOCKS = 150;
    localparam int DIR_ROWS     = 13;

    localparam simon_pkg::word_t ONES = {simon_pkg::WORD_W{1'b1}};
    localparam simon_pkg::word_t MSB  = simon_pkg::word_t'(1) << (simon_pkg::WORD_W - 1);

    typedef struct packed {
        logic             rekey;
        simon_pkg::word_t klo;
        simon_pkg::word_t khi;
        simon_pkg::word_t pr;
        simon_pkg::word_t pl;
        logic             has_exp;
        simon_pkg::word_t er;
        simon_pkg::word_t el;
    } dir_row_t;

    // published simon 128/128 vector in row 4
    localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
        '{1'b0, 64'h0, 64'h0, 64'h0, 64'h0, 1'b0, 64'h0, 64'h0},
        '{1'b0, 64'h0, 64'h0, ONES, ONES, 1'b0, 64'h0, 64'h0},
        '{1'b0, 64'h0, 64'h0, ONES, 64'h0, 1'b0, 64'h0, 64'h0},
        '{1'b0, 64'h0, 64'h0, 64'h0, ONES, 1'b0, 64'h0, 64'h0},
        '{1'b1, 64'h0706050403020100, 64'h0f0e0d0c0b0a0908,
          64'h6c6c657661727420, 64'h6373656420737265,
          1'b1, 64'h65aa832af84e0bbc, 64'h49681b1e1e54fe3f},
        '{1'b0, 64'h0, 64'h0, 64'h0, 64'h0, 1'b0, 64'h0, 64'h0},
        '{1'b0, 64'h0, 64'h0, 64'haaaaaaaaaaaaaaaa, 64'h5555555555555555,
          1'b0, 64'h0, 64'h0},
        '{1'b1, ONES, ONES, 64'h0, 64'h0, 1'b0, 64'h0, 64'h0},
        '{1'b0, 64'h0, 64'h0, ONES, ONES, 1'b0, 64'h0, 64'h0},
        '{1'b1, ONES, 64'h0, 64'h1, MSB, 1'b0, 64'h0, 64'h0},
        '{1'b1, 64'h0, ONES, MSB, 64'h1, 1'b0, 64'h0, 64'h0},
        '{1'b1, 64'h1, MSB, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa,
          1'b0, 64'h0, 64'h0},
        '{1'b1, 64'h0, 64'h0, ONES, 64'h0, 1'b0, 64'h0, 64'h0}
    };

    logic                                 clk = 1'b0;
    logic                                 rst_n = 1'b0;
    logic                                 s_axis_tvalid = 1'b0;
    logic                                 s_axis_tready;
    logic [2*simon_pkg::WORD_W-1:0]       s_axis_tdata = '0;   // plain_right, plain_left
    logic                                 m_axis_tvalid;
    logic                                 m_axis_tready = 1'b0;
    logic [2*simon_pkg::WORD_W-1:0]       m_axis_tdata;        // cipher_right, cipher_left
    logic                                 cfg_wen = 1'b0;
    logic [simon_pkg::CFG_INDEX_W-1:0]    cfg_index = simon_pkg::REG_KEY_LOW;
    simon_pkg::word_t                     cfg_wdata = '0;

    simon_pkg::word_t               key_lo = '0;
    simon_pkg::word_t               key_hi = '0;
    logic [2*simon_pkg::WORD_W-1:0] cipher_q [$];
    int                             mismatches = 0;
    int                             beats_out = 0;
    int                             cycle_cnt = 0;
    bit                             calm = 1'b0;

    simon128_128_block_encrypt_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wen       (cfg_wen),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // returns {cipher_left, cipher_right}
    function automatic logic [2*simon_pkg::WORD_W-1:0] simon_encipher(
        input simon_pkg::word_t klo, input simon_pkg::word_t khi,
        input simon_pkg::word_t pr, input simon_pkg::word_t pl);
        simon_pkg::word_t x;
        simon_pkg::word_t y;
        simon_pkg::word_t old;
        simon_pkg::word_t ka;
        simon_pkg::word_t kb;
        simon_pkg::word_t t;
        simon_pkg::word_t kn;
        int               zi;
        x  = pl;
        y  = pr;
        ka = klo;
        kb = khi;
        for (int r = 0; r < simon_pkg::ROUND_COUNT; r++)
        begin
            old = x;
            x = y ^ ({x[62:0], x[63]} & {x[55:0], x[63:56]}) ^ {x[61:0], x[63:62]} ^ ka;
            y = old;
            // z2 taken msb first, wrapping after its 62 bits
            zi = r % simon_pkg::Z2_LEN;
            t  = {kb[2:0], kb[63:3]};
            t  = t ^ {t[0], t[63:1]};
            kn = ~ka ^ t ^ simon_pkg::word_t'(simon_pkg::Z2_SEQ[simon_pkg::Z2_LEN-1-zi])
               ^ simon_pkg::word_t'(3);
            ka = kb;
            kb = kn;
        end
        return {x, y};
    endfunction

    function automatic simon_pkg::word_t rand_word();
        case ($urandom_range(9))
            0:       return '0;
            1:       return ONES;
            2:       return simon_pkg::word_t'(1) << $urandom_range(simon_pkg::WORD_W - 1);
            3:       return ~(simon_pkg::word_t'(1) << $urandom_range(simon_pkg::WORD_W - 1));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic flag_mismatch(input string what, input simon_pkg::word_t got,
                                 input simon_pkg::word_t want);
        $display("mismatch beat %0d %s: got %h want %h", beats_out, what, got, want);
        mismatches++;
    endtask

    // waits for the pipe to empty, then writes the chosen key words
    task automatic program_key(input simon_pkg::word_t lo, input simon_pkg::word_t hi,
                               input bit do_lo, input bit do_hi);
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (cipher_q.size() != 0)
            @(negedge clk);
        if (do_lo)
        begin
            cfg_wen   <= 1'b1;
            cfg_index <= simon_pkg::REG_KEY_LOW;
            cfg_wdata <= lo;
            key_lo = lo;
            @(negedge clk);
        end
        if (do_hi)
        begin
            cfg_wen   <= 1'b1;
            cfg_index <= simon_pkg::REG_KEY_HIGH;
            cfg_wdata <= hi;
            key_hi = hi;
            @(negedge clk);
        end
        cfg_wen <= 1'b0;
    endtask

    task automatic send_block(input simon_pkg::word_t pr, input simon_pkg::word_t pl,
                              input bit has_exp,
                              input simon_pkg::word_t er, input simon_pkg::word_t el);
        @(negedge clk);
        while (!calm && $urandom_range(99) < 38)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {pl, pr};
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (has_exp)
            cipher_q.push_back({el, er});
        else
            cipher_q.push_back(simon_encipher(key_lo, key_hi, pr, pl));
    endtask

    always @(negedge clk)
        m_axis_tready <= calm || ($urandom_range(99) >= 38);

    always @(posedge clk)
    begin
        logic [2*simon_pkg::WORD_W-1:0] want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (cipher_q.size() == 0)
            begin
                flag_mismatch("unexpected beat", m_axis_tdata[simon_pkg::WORD_W-1:0], '0);
            end
            else
            begin
                want = cipher_q.pop_front();
                if (m_axis_tdata[simon_pkg::WORD_W-1:0] !== want[simon_pkg::WORD_W-1:0])
                    flag_mismatch("cipher_right", m_axis_tdata[simon_pkg::WORD_W-1:0],
                                  want[simon_pkg::WORD_W-1:0]);
                if (m_axis_tdata[2*simon_pkg::WORD_W-1:simon_pkg::WORD_W]
                    !== want[2*simon_pkg::WORD_W-1:simon_pkg::WORD_W])
                    flag_mismatch("cipher_left",
                                  m_axis_tdata[2*simon_pkg::WORD_W-1:simon_pkg::WORD_W],
                                  want[2*simon_pkg::WORD_W-1:simon_pkg::WORD_W]);
            end
            beats_out++;
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin : stimulus
        dir_row_t         row;
        simon_pkg::word_t lo;
        simon_pkg::word_t hi;
        simon_pkg::word_t pr;
        simon_pkg::word_t pl;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // first rows run on the reset key of all zeros
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            row = DIR_TABLE[i];
            if (row.rekey)
                program_key(row.klo, row.khi, 1'b1, 1'b1);
            send_block(row.pr, row.pl, row.has_exp, row.er, row.el);
        end

        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            calm = (ph == 5) || (ph == 6);
            lo = rand_word();
            hi = rand_word();
            case (ph)
                0:       program_key(lo, hi, 1'b1, 1'b0);
                1:       program_key(lo, hi, 1'b0, 1'b1);
                7:       program_key('0, '0, 1'b1, 1'b1);
                12:      program_key(ONES, ONES, 1'b1, 1'b1);
                default: program_key(lo, hi, 1'b1, 1'b1);
            endcase
            for (int n = 0; n < PHASE_BLOCKS; n++)
            begin
                pr = ($urandom_range(7) == 0) ? rand_word() : {$urandom, $urandom};
                pl = ($urandom_range(7) == 0) ? rand_word() : {$urandom, $urandom};
                send_block(pr, pl, 1'b0, '0, '0);
            end
        end
        calm = 1'b0;

        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (cipher_q.size() != 0)
            @(posedge clk);
        // catch any stray beat still in the pipe
        repeat (simon_pkg::ROUND_COUNT + 8) @(posedge clk);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
